### design/kcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Knapsack constant-weight encryptor package
// Shared widths, opcodes, token and configuration types, and the elaboration
// time functions that build the binomial and modulus tables.
// ----------------------------------------------------------------------------
package kcw_pkg;

    localparam int KEY_COUNT_DEF = 7;
    localparam int KEY_W         = 17;
    localparam int MSG_W         = 6;
    localparam int WEIGHT_W      = 3;
    localparam int IDX_W         = 3;
    localparam int MAX_WEIGHT    = (1 << WEIGHT_W) - 1;
    localparam int SUM_W         = KEY_W + WEIGHT_W;
    localparam int BINOM_W       = MSG_W + 1;
    localparam int BINOM_CAP     = 1 << MSG_W;
    localparam int STEP_W        = $clog2(SUM_W + 1);
    localparam int IN_DATA_W     = 32;
    localparam int OUT_DATA_W    = 24;

    localparam logic               OP_WRITE     = 1'b0;
    localparam logic               OP_ENCRYPT   = 1'b1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 3'd4;

    typedef struct packed {
        logic                valid;
        logic [MSG_W-1:0]    msg;
        logic [WEIGHT_W-1:0] left;
        logic [SUM_W-1:0]    sum;
    } t_token;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] index;
        logic [KEY_W-1:0] value;
    } t_key_wr;

    typedef struct packed {
        logic              enable;
        logic [SUM_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } t_red_cfg;

    function automatic logic [BINOM_W-1:0] binom_sat(input int n, input int k);
        int row [0:MAX_WEIGHT];
        int r;
        int j;
        int s;
        for (j = 0; j <= MAX_WEIGHT; j++) begin
            row[j] = 0;
        end
        row[0] = 1;
        for (r = 1; r <= n; r++) begin
            for (j = MAX_WEIGHT; j >= 1; j--) begin
                s = row[j] + row[j-1];
                row[j] = (s > BINOM_CAP) ? BINOM_CAP : s;
            end
        end
        if (k > n || k > MAX_WEIGHT) begin
            return '0;
        end
        return BINOM_W'(row[k]);
    endfunction

    function automatic longint mod_pow(input int k, input int w);
        longint p;
        int i;
        p = 1;
        for (i = 0; i < w; i++) begin
            p = p * longint'(k);
        end
        return p - 1;
    endfunction

    function automatic logic red_en(input int k, input int w);
        longint m;
        m = mod_pow(k, w);
        return (w >= 1) && (m < (longint'(1) << SUM_W));
    endfunction

    function automatic int red_shift(input int k, input int w);
        longint m;
        int b;
        int i;
        m = mod_pow(k, w);
        b = 0;
        for (i = 0; i < 63; i++) begin
            if (m[i]) begin
                b = i + 1;
            end
        end
        if (!red_en(k, w)) begin
            return 0;
        end
        return SUM_W - b;
    endfunction

    function automatic logic [SUM_W-1:0] red_div(input int k, input int w);
        logic [63:0] d;
        d = 64'(mod_pow(k, w)) << red_shift(k, w);
        if (!red_en(k, w)) begin
            return '0;
        end
        return d[SUM_W-1:0];
    endfunction

endpackage

### design/kcw_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Knapsack encoder cell
// Holds one public key word and performs one step of the constant-weight
// encoding on the token that passes through it, adding its key when selected.
// ----------------------------------------------------------------------------
module kcw_cell #(
    parameter int KEY_COUNT = kcw_pkg::KEY_COUNT_DEF,
    parameter int INDEX     = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  kcw_pkg::t_key_wr i_wr,
    input  kcw_pkg::t_token  i_tok,
    output kcw_pkg::t_token  o_tok
);
    import kcw_pkg::*;

    localparam int N = KEY_COUNT - 1 - INDEX;

    logic [BINOM_W-1:0] c_binom [0:MAX_WEIGHT];
    logic [BINOM_W-1:0] c_t;
    logic               c_take;
    logic [KEY_W-1:0]   r_key;
    t_token             r_tok;
    t_token             n_tok;

    for (genvar k = 0; k <= MAX_WEIGHT; k++) begin : g_binom
        assign c_binom[k] = binom_sat(N, k);
    end

    assign c_t    = c_binom[i_tok.left];
    assign c_take = (i_tok.left != '0) && ({1'b0, i_tok.msg} >= c_t);

    always_comb begin
        n_tok = i_tok;
        if (c_take) begin
            n_tok.msg  = i_tok.msg - c_t[MSG_W-1:0];
            n_tok.left = i_tok.left - 1'b1;
            n_tok.sum  = i_tok.sum + SUM_W'(r_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.msg  <= n_tok.msg;
        r_tok.left <= n_tok.left;
        r_tok.sum  <= n_tok.sum;
        if (i_wr.en && (int'(i_wr.index) == INDEX)) begin
            r_key <= i_wr.value;
        end
    end

    assign o_tok = r_tok;

endmodule

### design/kcw_reducer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular reducer
// Reduces the raw key sum modulo the selected modulus by shift and
// conditional subtract, one divisor position per cycle.
// ----------------------------------------------------------------------------
module kcw_reducer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [kcw_pkg::SUM_W-1:0]  i_value,
    input  kcw_pkg::t_red_cfg          i_cfg,
    output logic                       o_done,
    output logic [kcw_pkg::SUM_W-1:0]  o_value
);
    import kcw_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [SUM_W-1:0]  r_x;
    logic [SUM_W-1:0]  r_d;
    logic [STEP_W-1:0] r_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= i_cfg.enable;
                r_done <= !i_cfg.enable;
            end else if (r_busy && r_j == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_x <= i_value;
            r_d <= i_cfg.divisor;
            r_j <= i_cfg.steps;
        end else if (r_busy) begin
            if (r_x >= r_d) begin
                r_x <= r_x - r_d;
            end
            r_d <= r_d >> 1;
            if (r_j != '0) begin
                r_j <= r_j - 1'b1;
            end
        end
    end

    assign o_done  = r_done;
    assign o_value = r_x;

endmodule

### design/knapsack_constant_weight_encryptor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Knapsack constant-weight encryptor core
// Loads public key words and encrypts messages with a constant-weight
// encoding followed by a modular knapsack sum.
// ----------------------------------------------------------------------------
// A key write transaction is taken whenever no encryption is in flight, and
// writes may then follow each other in every cycle. An encrypt transaction
// passes through a row of KEY_COUNT cells, one cell per cycle. It then passes
// through a modular reducer, which skips the reduction when the weight is zero
// or the modulus exceeds the sum width. The result is registered and, once the
// output register is free or being read, loaded into it; the input reopens as
// that load happens. The block takes no new transaction while an encryption is
// in flight, but it does take one while a finished result still waits in the
// output register; a second finished result waits until that register is read.
// ----------------------------------------------------------------------------
module knapsack_constant_weight_encryptor_core #(
    parameter int KEY_COUNT = kcw_pkg::KEY_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [kcw_pkg::WEIGHT_W-1:0]        i_cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // key_index [2:0], key_value [19:3], message [25:20], zero [31:26]
    input  logic [kcw_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // opcode [0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // ciphertext [16:0], zero [23:17]
    output logic [kcw_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // range_error [0]
    output logic                                m_axis_tuser
);
    import kcw_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHAIN = 2'd1;
    localparam logic [1:0] S_RED   = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [WEIGHT_W-1:0] r_weight;
    logic                r_err;
    logic [KEY_W-1:0]    r_res;
    logic                r_out_valid;
    logic [KEY_W-1:0]    r_out_ct;
    logic                r_out_err;

    logic [BINOM_W-1:0]  c_total   [0:MAX_WEIGHT];
    t_red_cfg            c_red_tab [0:MAX_WEIGHT];
    t_token              c_tok     [0:KEY_COUNT];
    logic [KEY_COUNT-1:0] c_tok_valid;

    logic [IDX_W-1:0]    c_index;
    logic [KEY_W-1:0]    c_value;
    logic [MSG_W-1:0]    c_msg;
    logic                c_accept;
    logic                c_encrypt;
    logic                c_range_err;
    logic                c_chain_done;
    logic                c_out_load;
    t_key_wr             c_wr;
    logic                c_red_done;
    logic [SUM_W-1:0]    c_red_value;

    for (genvar w = 0; w <= MAX_WEIGHT; w++) begin : g_tab
        assign c_total[w]           = binom_sat(KEY_COUNT, w);
        assign c_red_tab[w].enable  = red_en(KEY_COUNT, w);
        assign c_red_tab[w].divisor = red_div(KEY_COUNT, w);
        assign c_red_tab[w].steps   = STEP_W'(red_shift(KEY_COUNT, w));
    end

    assign c_index     = s_axis_tdata[IDX_W-1:0];
    assign c_value     = s_axis_tdata[IDX_W+KEY_W-1:IDX_W];
    assign c_msg       = s_axis_tdata[IDX_W+KEY_W+MSG_W-1:IDX_W+KEY_W];
    assign s_axis_tready = (r_state == S_IDLE);
    assign c_accept    = s_axis_tvalid && s_axis_tready;
    assign c_encrypt   = c_accept && (s_axis_tuser == OP_ENCRYPT);
    assign c_range_err = ({1'b0, c_msg} >= c_total[r_weight]);

    assign c_wr.en    = c_accept && (s_axis_tuser == OP_WRITE);
    assign c_wr.index = c_index;
    assign c_wr.value = c_value;

    assign c_tok[0].valid = c_encrypt;
    assign c_tok[0].msg   = c_msg;
    assign c_tok[0].left  = r_weight;
    assign c_tok[0].sum   = '0;

    for (genvar i = 0; i < KEY_COUNT; i++) begin : g_cell
        kcw_cell #(
            .KEY_COUNT (KEY_COUNT),
            .INDEX     (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (c_wr),
            .i_tok   (c_tok[i]),
            .o_tok   (c_tok[i+1])
        );
        assign c_tok_valid[i] = c_tok[i+1].valid;
    end

    assign c_chain_done = c_tok[KEY_COUNT].valid;

    kcw_reducer u_reducer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_chain_done),
        .i_value (c_tok[KEY_COUNT].sum),
        .i_cfg   (c_red_tab[r_weight]),
        .o_done  (c_red_done),
        .o_value (c_red_value)
    );

    assign c_out_load = (r_state == S_HOLD) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (c_encrypt) begin
                    n_state = S_CHAIN;
                end
            end
            S_CHAIN: begin
                if (c_chain_done) begin
                    n_state = S_RED;
                end
            end
            S_RED: begin
                if (c_red_done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (c_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_weight    <= WEIGHT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_weight <= i_cfg_wr_data;
            end
            if (c_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (c_encrypt) begin
            r_err <= c_range_err;
        end
        if (r_state == S_RED && c_red_done) begin
            r_res <= r_err ? '0 : c_red_value[KEY_W-1:0];
        end
        if (c_out_load) begin
            r_out_ct  <= r_res;
            r_out_err <= r_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_ct);
    assign m_axis_tuser  = r_out_err;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(c_tok_valid) <= 1)
        else $error("more than one token in the cell row");

    a_token_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_tok_valid != '0) |-> (r_state == S_CHAIN))
        else $error("token in the cell row outside the chain state");

    a_encrypt_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_encrypt |=> (r_state == S_CHAIN))
        else $error("encrypt transaction did not start the cell row");

    a_red_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_red_done |-> (r_state == S_RED))
        else $error("reducer finished outside the reduce state");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("range error with a nonzero ciphertext");

endmodule

### test/kcw_cipher_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Knapsack encryptor ciphertext monitor
// Watches the configuration port and both stream channels of the encryptor,
// keeps its own copy of the key table and the weight, computes the expected
// ciphertext and range flag of every encrypt transaction, and compares each
// result transaction with the oldest pending expectation.
// ----------------------------------------------------------------------------
module kcw_cipher_monitor #(
    parameter int KEY_COUNT = kcw_pkg::KEY_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [kcw_pkg::WEIGHT_W-1:0]      i_cfg_wr_data,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [kcw_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  logic                              i_s_tuser,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [kcw_pkg::OUT_DATA_W-1:0]    i_m_tdata,
    input  logic                              i_m_tuser,
    output int                                o_mismatches,
    output int                                o_outstanding,
    output int                                o_encryptions,
    output int                                o_range_errors
);
    import kcw_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0] ciphertext;
        logic             range_error;
    } t_cipher_result;

    logic [KEY_W-1:0]    key_words [0:KEY_COUNT-1];
    logic [WEIGHT_W-1:0] weight = WEIGHT_RESET;
    t_cipher_result      pending_ciphers [$];
    int                  mismatch_count = 0;
    int                  pending_count  = 0;
    int                  encrypt_count  = 0;
    int                  range_count    = 0;

    assign o_mismatches   = mismatch_count;
    assign o_outstanding  = pending_count;
    assign o_encryptions  = encrypt_count;
    assign o_range_errors = range_count;

    function automatic longint unsigned choose(input int n, input int k);
        longint unsigned row [0:MAX_WEIGHT];
        int r;
        int j;
        if (k > n || k > MAX_WEIGHT) begin
            return 0;
        end
        for (j = 0; j <= MAX_WEIGHT; j++) begin
            row[j] = 0;
        end
        row[0] = 1;
        for (r = 1; r <= n; r++) begin
            for (j = MAX_WEIGHT; j >= 1; j--) begin
                row[j] = row[j] + row[j-1];
            end
        end
        return row[k];
    endfunction

    function automatic t_cipher_result encrypt_message(input logic [MSG_W-1:0] message,
                                                       input logic [WEIGHT_W-1:0] w);
        longint unsigned m;
        longint unsigned modulus;
        longint unsigned sum;
        longint unsigned t;
        int i;
        int left;
        t_cipher_result r;
        r = '0;
        m = message;
        if (m >= choose(KEY_COUNT, int'(w))) begin
            r.range_error = 1'b1;
            return r;
        end
        if (w == 0) begin
            return r;
        end
        modulus = 1;
        for (i = 0; i < int'(w); i++) begin
            modulus = modulus * KEY_COUNT;
        end
        modulus = modulus - 1;
        sum  = 0;
        left = int'(w);
        for (i = 1; i <= KEY_COUNT; i++) begin
            t = choose(KEY_COUNT - i, left);
            if (left > 0 && m >= t) begin
                m    = m - t;
                left = left - 1;
                sum  = (sum + longint'(key_words[i-1]) % modulus) % modulus;
            end
        end
        r.ciphertext = sum[KEY_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_cipher_result exp_r;
        if (!i_rst_n) begin
            weight = WEIGHT_RESET;
            pending_ciphers.delete();
        end else begin
            if (i_cfg_wr_en) begin
                weight = i_cfg_wr_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_WRITE) begin
                    if (int'(i_s_tdata[2:0]) < KEY_COUNT) begin
                        key_words[i_s_tdata[2:0]] = i_s_tdata[19:3];
                    end
                end else begin
                    exp_r = encrypt_message(i_s_tdata[25:20], weight);
                    pending_ciphers = {pending_ciphers, exp_r};
                    encrypt_count++;
                    if (exp_r.range_error) begin
                        range_count++;
                    end
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pending_ciphers.size() == 0) begin
                    report_mismatch($sformatf("result with no pending encryption, data %0d",
                                              i_m_tdata[KEY_W-1:0]));
                end else begin
                    exp_r = pending_ciphers.pop_front();
                    if (i_m_tdata[KEY_W-1:0] !== exp_r.ciphertext) begin
                        report_mismatch($sformatf("ciphertext expected %0d, got %0d",
                                                  exp_r.ciphertext, i_m_tdata[KEY_W-1:0]));
                    end
                    if (i_m_tuser !== exp_r.range_error) begin
                        report_mismatch($sformatf("range_error expected %0b, got %0b",
                                                  exp_r.range_error, i_m_tuser));
                    end
                end
            end
        end
        pending_count = pending_ciphers.size();
    end

endmodule

### test/knapsack_constant_weight_encryptor_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Knapsack constant-weight encryptor testbench
// Loads the key table, runs directed encryptions across the weight extremes,
// then random key writes and encryptions over several weights under random
// backpressure and source gaps, with one long output stall. A separate
// monitor predicts every ciphertext and counts mismatches.
// ----------------------------------------------------------------------------
module knapsack_constant_weight_encryptor_core_tb;
    import kcw_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int RAND_PHASES   = 9;
    localparam int PHASE_ITEMS   = 170;
    localparam int LIMIT_NS      = 5_000_000;
    localparam int KEY_MAX       = 117647;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_wr_en   = 1'b0;
    logic [WEIGHT_W-1:0]     i_cfg_wr_data = WEIGHT_RESET;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;
    logic                    s_axis_tuser  = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    m_axis_tuser;

    int                      send_idle_pct = 35;
    int                      recv_idle_pct = 48;
    int                      hold_requests = 0;
    logic [WEIGHT_W-1:0]     cur_weight    = WEIGHT_RESET;
    int                      weight_writes = 0;
    int                      msg_span [0:7] = '{1, 7, 21, 35, 35, 21, 7, 1};
    logic [WEIGHT_W-1:0]     phase_weight [0:RAND_PHASES-1] =
                                 '{3'd1, 3'd6, 3'd3, 3'd5, 3'd2, 3'd4, 3'd6, 3'd1, 3'd4};

    int                      mismatches;
    int                      outstanding;
    int                      encryptions;
    int                      range_errors;

    always #CLK_HALF i_clk = ~i_clk;

    knapsack_constant_weight_encryptor_core #(
        .KEY_COUNT(KEY_COUNT_DEF)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    kcw_cipher_monitor #(
        .KEY_COUNT(KEY_COUNT_DEF)
    ) u_cipher_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tuser      (s_axis_tuser),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .i_m_tuser      (m_axis_tuser),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_encryptions  (encryptions),
        .o_range_errors (range_errors)
    );

    task automatic offer(input logic op, input logic [IDX_W-1:0] idx,
                         input logic [KEY_W-1:0] val, input logic [MSG_W-1:0] msg);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, msg, val, idx};
        @(negedge i_clk);
        while (!s_axis_tready) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (outstanding != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_weight(input logic [WEIGHT_W-1:0] w);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_weight = w;
        weight_writes++;
    endtask

    initial begin : output_side
        int held;
        int holds_served;
        holds_served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served++;
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    m_axis_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("Timeout with %0d results still pending.", outstanding);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int                  phase;
        int                  n;
        int                  pick;
        logic                op;
        logic [IDX_W-1:0]    idx;
        logic [KEY_W-1:0]    val;
        logic [MSG_W-1:0]    msg;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every table entry is written before the first encryption reads it.
        offer(OP_WRITE,   3'd0, 17'd117647, 6'd0);
        offer(OP_WRITE,   3'd1, 17'd0,      6'd63);
        offer(OP_WRITE,   3'd2, 17'd2400,   6'd0);
        offer(OP_WRITE,   3'd3, 17'd2399,   6'd0);
        offer(OP_WRITE,   3'd4, 17'h15555,  6'd0);
        offer(OP_WRITE,   3'd5, 17'h0AAAA,  6'd0);
        offer(OP_WRITE,   3'd6, 17'd1,      6'd0);
        offer(OP_WRITE,   3'd7, 17'd12345,  6'd0);
        offer(OP_ENCRYPT, 3'd0, 17'd0,      6'd0);
        offer(OP_ENCRYPT, 3'd7, 17'h1FFFF,  6'd34);
        offer(OP_ENCRYPT, 3'd0, 17'd0,      6'd1);
        offer(OP_ENCRYPT, 3'd0, 17'd0,      6'd17);
        offer(OP_ENCRYPT, 3'd0, 17'd0,      6'd33);

        write_weight(3'd0);
        offer(OP_ENCRYPT, 3'd0, 17'd0, 6'd0);
        offer(OP_ENCRYPT, 3'd0, 17'd0, 6'd1);
        offer(OP_ENCRYPT, 3'd0, 17'd0, 6'd34);

        write_weight(3'd7);
        offer(OP_ENCRYPT, 3'd0, 17'd0, 6'd0);
        offer(OP_ENCRYPT, 3'd0, 17'd0, 6'd1);

        write_weight(3'd1);
        offer(OP_ENCRYPT, 3'd0, 17'd0, 6'd0);
        offer(OP_ENCRYPT, 3'd0, 17'd0, 6'd6);
        offer(OP_ENCRYPT, 3'd0, 17'd0, 6'd7);
        offer(OP_ENCRYPT, 3'd0, 17'd0, 6'd34);

        write_weight(3'd6);
        offer(OP_ENCRYPT, 3'd0, 17'd0, 6'd0);
        offer(OP_ENCRYPT, 3'd0, 17'd0, 6'd6);
        offer(OP_ENCRYPT, 3'd0, 17'd0, 6'd7);

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase == 3) begin
                send_idle_pct = 48;
                recv_idle_pct = 35;
            end else if (phase == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_weight(phase_weight[phase]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 4 && n == 60) begin
                    hold_requests++;
                end
                op   = ($urandom_range(0, 99) < 65) ? OP_ENCRYPT : OP_WRITE;
                idx  = ($urandom_range(0, 19) == 0) ? 3'd7 : IDX_W'($urandom_range(0, 6));
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    val = '0;
                end else if (pick == 1) begin
                    val = KEY_W'(KEY_MAX);
                end else begin
                    val = KEY_W'($urandom_range(0, KEY_MAX));
                end
                if ($urandom_range(0, 9) < 8) begin
                    msg = MSG_W'($urandom_range(0, msg_span[cur_weight] - 1));
                end else begin
                    msg = MSG_W'($urandom_range(0, 34));
                end
                offer(op, idx, val, msg);
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();

        $display("Covered %0d encryptions (%0d out of range) over %0d weight settings,",
                 encryptions, range_errors, weight_writes + 1);
        $display("with key writes, ignored writes and a %0d-cycle output stall.",
                 HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
